// ----- sv/hsvc_pkg.sv -----
// shared types and constants of the hsv to rgb converter
package hsvc_pkg;

    // hue full range and width of one of the six sectors
    localparam int HUE_SPAN     = 360;
    localparam int SECTOR_COUNT = 6;
    localparam int SECTOR_SPAN  = HUE_SPAN / SECTOR_COUNT;

    // q16 unity and rounding constants
    localparam int ONE_Q16      = 65536;
    localparam int ROUND_HALF   = 32768;
    localparam int CHAN_SCALE   = 255;

    // fraction = offset * 65536 / 60 = offset * 1092 + offset * 4 / 15
    // the 4/15 part is taken as (offset * 17480) >> 16, exact for offset < 60
    localparam int FRAC_INT     = ONE_Q16 / SECTOR_SPAN;
    localparam int FRAC_CORR    = 17480;

    // hue sector codes
    typedef enum logic [2:0] {
        SEC_RED     = 3'd0,
        SEC_YELLOW  = 3'd1,
        SEC_GREEN   = 3'd2,
        SEC_CYAN    = 3'd3,
        SEC_BLUE    = 3'd4,
        SEC_MAGENTA = 3'd5
    } hsvc_sector_t;

    // after hue reduction: sector and offset within sector
    typedef struct packed {
        hsvc_sector_t sector;
        logic [5:0]   offset;
        logic [7:0]   sat;
        logic [7:0]   bri;
    } hsvc_split_t;

    // after fraction: q16 fraction within sector
    typedef struct packed {
        hsvc_sector_t sector;
        logic [15:0]  frac;
        logic [7:0]   sat;
        logic [7:0]   bri;
    } hsvc_frac_t;

    // after saturation mix: s, s*f and s - s*f
    typedef struct packed {
        hsvc_sector_t sector;
        logic [15:0]  sat_q;
        logic [15:0]  sf;
        logic [15:0]  ta;
        logic [7:0]   bri;
        logic         gray;
    } hsvc_mix_t;

    // the four candidate channel terms in q16
    typedef struct packed {
        hsvc_sector_t sector;
        logic [15:0]  v;
        logic [15:0]  p;
        logic [15:0]  q;
        logic [15:0]  t;
        logic [7:0]   bri;
        logic         gray;
    } hsvc_term_t;

endpackage

// ----- sv/hsvc_if.sv -----
// stream interfaces for hsv requests and rgb results
interface hsvc_hsv_if;
    logic       valid;
    logic       ready;
    logic [8:0] hue;
    logic [7:0] saturation;
    logic [7:0] brightness;

    modport source (output valid, hue, saturation, brightness, input ready);
    modport sink   (input valid, hue, saturation, brightness, output ready);
endinterface

interface hsvc_rgb_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;

    modport source (output valid, red, green, blue, input ready);
    modport sink   (input valid, red, green, blue, output ready);
endinterface

// ----- sv/hsvc_sector_stage.sv -----
// two pipeline stages: hue wrap and sector split, then q16 fraction
module hsvc_sector_stage
    import hsvc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        up_valid,
    output logic        up_ready,
    input  logic [8:0]  hue,
    input  logic [7:0]  saturation,
    input  logic [7:0]  brightness,
    output logic        dn_valid,
    input  logic        dn_ready,
    output hsvc_frac_t  dn_data
);

    logic        split_vld_reg;
    hsvc_split_t split_reg;
    hsvc_split_t split_next;
    logic        frac_vld_reg;
    hsvc_frac_t  frac_reg;
    hsvc_frac_t  frac_next;
    logic        split_ready;
    logic        frac_ready;
    logic [8:0]  h_wrap;
    logic [8:0]  ofs_wide;
    logic [15:0] frac_int;
    logic [20:0] frac_corr;

    // stage advance conditions
    assign frac_ready  = !frac_vld_reg || dn_ready;
    assign split_ready = !split_vld_reg || frac_ready;
    assign up_ready    = split_ready;

    // hue wrap and sector search
    always_comb
    begin
        h_wrap = (hue >= 9'(HUE_SPAN)) ? hue - 9'(HUE_SPAN) : hue;
        if (h_wrap >= 9'(5 * SECTOR_SPAN))
        begin
            split_next.sector = SEC_MAGENTA;
            ofs_wide          = h_wrap - 9'(5 * SECTOR_SPAN);
        end
        else if (h_wrap >= 9'(4 * SECTOR_SPAN))
        begin
            split_next.sector = SEC_BLUE;
            ofs_wide          = h_wrap - 9'(4 * SECTOR_SPAN);
        end
        else if (h_wrap >= 9'(3 * SECTOR_SPAN))
        begin
            split_next.sector = SEC_CYAN;
            ofs_wide          = h_wrap - 9'(3 * SECTOR_SPAN);
        end
        else if (h_wrap >= 9'(2 * SECTOR_SPAN))
        begin
            split_next.sector = SEC_GREEN;
            ofs_wide          = h_wrap - 9'(2 * SECTOR_SPAN);
        end
        else if (h_wrap >= 9'(SECTOR_SPAN))
        begin
            split_next.sector = SEC_YELLOW;
            ofs_wide          = h_wrap - 9'(SECTOR_SPAN);
        end
        else
        begin
            split_next.sector = SEC_RED;
            ofs_wide          = h_wrap;
        end
        split_next.offset = ofs_wide[5:0];
        split_next.sat    = saturation;
        split_next.bri    = brightness;
    end

    // fraction by constant reciprocal
    always_comb
    begin
        frac_int         = 16'(split_reg.offset * 16'(FRAC_INT));
        frac_corr        = 21'(split_reg.offset * 21'(FRAC_CORR));
        frac_next.sector = split_reg.sector;
        frac_next.frac   = frac_int + {11'd0, frac_corr[20:16]};
        frac_next.sat    = split_reg.sat;
        frac_next.bri    = split_reg.bri;
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            split_vld_reg <= 1'b0;
            frac_vld_reg  <= 1'b0;
        end
        else
        begin
            if (split_ready)
                split_vld_reg <= up_valid;
            if (frac_ready)
                frac_vld_reg <= split_vld_reg;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (split_ready && up_valid)
            split_reg <= split_next;
        if (frac_ready && split_vld_reg)
            frac_reg <= frac_next;
    end

    assign dn_valid = frac_vld_reg;
    assign dn_data  = frac_reg;

`ifndef SYNTHESIS
    // offset stays inside one sector
    a_offset_range: assert property (@(posedge clk) disable iff (!rst_n)
        split_vld_reg |-> (split_reg.offset < 6'(SECTOR_SPAN)))
        else $error("sector offset out of range");

    // fraction stays below unity
    a_frac_range: assert property (@(posedge clk) disable iff (!rst_n)
        frac_vld_reg |-> (frac_reg.frac <= 16'(ONE_Q16 - FRAC_INT)))
        else $error("fraction out of range");
`endif

endmodule

// ----- sv/hsvc_term_stage.sv -----
// two pipeline stages: saturation mix, then the v, p, q, t terms
module hsvc_term_stage
    import hsvc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        up_valid,
    output logic        up_ready,
    input  hsvc_frac_t  up_data,
    output logic        dn_valid,
    input  logic        dn_ready,
    output hsvc_term_t  dn_data
);

    logic        mix_vld_reg;
    hsvc_mix_t   mix_reg;
    hsvc_mix_t   mix_next;
    logic        term_vld_reg;
    hsvc_term_t  term_reg;
    hsvc_term_t  term_next;
    logic        mix_ready;
    logic        term_ready;
    logic [23:0] sf_prod;
    logic [16:0] comp_p;
    logic [16:0] comp_q;
    logic [16:0] comp_t;
    logic [24:0] prod_p;
    logic [24:0] prod_q;
    logic [24:0] prod_t;

    // stage advance conditions
    assign term_ready = !term_vld_reg || dn_ready;
    assign mix_ready  = !mix_vld_reg || term_ready;
    assign up_ready   = mix_ready;

    // s * f and s - s * f
    always_comb
    begin
        sf_prod         = {16'd0, up_data.sat} * {8'd0, up_data.frac};
        mix_next.sector = up_data.sector;
        mix_next.sat_q  = {up_data.sat, 8'd0};
        mix_next.sf     = sf_prod[23:8];
        mix_next.ta     = {up_data.sat, 8'd0} - sf_prod[23:8];
        mix_next.bri    = up_data.bri;
        mix_next.gray   = (up_data.sat == 8'd0);
    end

    // v * (1 - a) for the three terms
    always_comb
    begin
        comp_p           = 17'(ONE_Q16) - {1'b0, mix_reg.sat_q};
        comp_q           = 17'(ONE_Q16) - {1'b0, mix_reg.sf};
        comp_t           = 17'(ONE_Q16) - {1'b0, mix_reg.ta};
        prod_p           = {17'd0, mix_reg.bri} * {8'd0, comp_p};
        prod_q           = {17'd0, mix_reg.bri} * {8'd0, comp_q};
        prod_t           = {17'd0, mix_reg.bri} * {8'd0, comp_t};
        term_next.sector = mix_reg.sector;
        term_next.v      = {mix_reg.bri, 8'd0};
        term_next.p      = prod_p[23:8];
        term_next.q      = prod_q[23:8];
        term_next.t      = prod_t[23:8];
        term_next.bri    = mix_reg.bri;
        term_next.gray   = mix_reg.gray;
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mix_vld_reg  <= 1'b0;
            term_vld_reg <= 1'b0;
        end
        else
        begin
            if (mix_ready)
                mix_vld_reg <= up_valid;
            if (term_ready)
                term_vld_reg <= mix_vld_reg;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (mix_ready && up_valid)
            mix_reg <= mix_next;
        if (term_ready && mix_vld_reg)
            term_reg <= term_next;
    end

    assign dn_valid = term_vld_reg;
    assign dn_data  = term_reg;

`ifndef SYNTHESIS
    // no term exceeds v
    a_term_bound: assert property (@(posedge clk) disable iff (!rst_n)
        term_vld_reg |-> (term_reg.p <= term_reg.v && term_reg.q <= term_reg.v
                          && term_reg.t <= term_reg.v))
        else $error("channel term above value");
`endif

endmodule

// ----- sv/hsvc_round_stage.sv -----
// output stage: sector channel select, scale by 255 and round
module hsvc_round_stage
    import hsvc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        up_valid,
    output logic        up_ready,
    input  hsvc_term_t  up_data,
    output logic        dn_valid,
    input  logic        dn_ready,
    output logic [7:0]  red,
    output logic [7:0]  green,
    output logic [7:0]  blue
);

    logic        out_vld_reg;
    logic [7:0]  red_reg;
    logic [7:0]  green_reg;
    logic [7:0]  blue_reg;
    logic [7:0]  red_next;
    logic [7:0]  green_next;
    logic [7:0]  blue_next;
    logic [15:0] r_term;
    logic [15:0] g_term;
    logic [15:0] b_term;
    logic [24:0] r_scaled;
    logic [24:0] g_scaled;
    logic [24:0] b_scaled;

    assign up_ready = !out_vld_reg || dn_ready;

    // sector table
    always_comb
    begin
        case (up_data.sector)
            SEC_RED:
            begin
                r_term = up_data.v; g_term = up_data.t; b_term = up_data.p;
            end
            SEC_YELLOW:
            begin
                r_term = up_data.q; g_term = up_data.v; b_term = up_data.p;
            end
            SEC_GREEN:
            begin
                r_term = up_data.p; g_term = up_data.v; b_term = up_data.t;
            end
            SEC_CYAN:
            begin
                r_term = up_data.p; g_term = up_data.q; b_term = up_data.v;
            end
            SEC_BLUE:
            begin
                r_term = up_data.t; g_term = up_data.p; b_term = up_data.v;
            end
            default:
            begin
                r_term = up_data.v; g_term = up_data.p; b_term = up_data.q;
            end
        endcase
    end

    // scale to 0..255, round half up; gray passes brightness through
    always_comb
    begin
        r_scaled = 25'(r_term * 25'(CHAN_SCALE)) + 25'(ROUND_HALF);
        g_scaled = 25'(g_term * 25'(CHAN_SCALE)) + 25'(ROUND_HALF);
        b_scaled = 25'(b_term * 25'(CHAN_SCALE)) + 25'(ROUND_HALF);
        if (up_data.gray)
        begin
            red_next   = up_data.bri;
            green_next = up_data.bri;
            blue_next  = up_data.bri;
        end
        else
        begin
            red_next   = r_scaled[23:16];
            green_next = g_scaled[23:16];
            blue_next  = b_scaled[23:16];
        end
    end

    // valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (up_ready)
            out_vld_reg <= up_valid;
    end

    // result registers
    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    assign dn_valid = out_vld_reg;
    assign red      = red_reg;
    assign green    = green_reg;
    assign blue     = blue_reg;

`ifndef SYNTHESIS
    // a gray request gives three equal channels
    a_gray_equal: assert property (@(posedge clk) disable iff (!rst_n)
        (up_valid && up_ready && up_data.gray)
            |=> (red_reg == green_reg && green_reg == blue_reg))
        else $error("gray request gave unequal channels");
`endif

endmodule

// ----- sv/hsv_to_rgb_converter.sv -----
// hsv to rgb converter
// throughput one pixel per cycle unless rgb stalls, through five register stages; the ready chain
// lets every stage advance whenever the stage after it moves or is empty
// a stall on rgb holds the full stages in place without loss or repeat
// reset (rst_n low, asynchronous) clears the stage valid bits only
// top level: hue split, saturation mix and term stages, then rounding
module hsv_to_rgb_converter
    import hsvc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    hsvc_hsv_if.sink   hsv,
    hsvc_rgb_if.source rgb
);

    logic       frac_valid;
    logic       frac_ready;
    hsvc_frac_t frac_data;
    logic       term_valid;
    logic       term_ready;
    hsvc_term_t term_data;

    // hue reduction and sector fraction
    hsvc_sector_stage u_sector (
        .clk        (clk),
        .rst_n      (rst_n),
        .up_valid   (hsv.valid),
        .up_ready   (hsv.ready),
        .hue        (hsv.hue),
        .saturation (hsv.saturation),
        .brightness (hsv.brightness),
        .dn_valid   (frac_valid),
        .dn_ready   (frac_ready),
        .dn_data    (frac_data)
    );

    // saturation mix and channel terms
    hsvc_term_stage u_term (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (frac_valid),
        .up_ready (frac_ready),
        .up_data  (frac_data),
        .dn_valid (term_valid),
        .dn_ready (term_ready),
        .dn_data  (term_data)
    );

    // channel select and rounding
    hsvc_round_stage u_round (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (term_valid),
        .up_ready (term_ready),
        .up_data  (term_data),
        .dn_valid (rgb.valid),
        .dn_ready (rgb.ready),
        .red      (rgb.red),
        .green    (rgb.green),
        .blue     (rgb.blue)
    );

endmodule

// ----- test/tb_hsv_to_rgb_converter.sv -----
// testbench for the hsv to rgb converter: random and directed pixels checked in order
`timescale 1ns / 100ps

module tb_hsv_to_rgb_converter
    import hsvc_pkg::*;
();

    // saturation and value spans of the block
    localparam int SAT_FULL     = 256;
    localparam int VAL_FULL     = 256;
    localparam int RANDOM_ITEMS = 1500;
    localparam int STALL_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 10;

    typedef struct {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_pixel_t;

    // expected rgb pixels, in request order
    class pixel_scoreboard;
        rgb_pixel_t expected_rgb[$];
        int         mismatches;

        function new();
            mismatches = 0;
        endfunction

        // v * (1 - a) in q16
        function logic [16:0] shade(logic [16:0] v_q, logic [16:0] a_q);
            longint unsigned prod;
            prod = longint'(v_q) * (longint'(ONE_Q16) - longint'(a_q));
            return 17'(prod >> 16);
        endfunction

        // q16 term to byte, round half up
        function logic [7:0] to_channel(logic [16:0] term_q);
            longint unsigned c;
            c = (longint'(term_q) * CHAN_SCALE + ROUND_HALF) >> 16;
            return (c > 255) ? 8'd255 : 8'(c);
        endfunction

        function rgb_pixel_t rgb_of_hsv(logic [8:0] hue, logic [7:0] sat, logic [7:0] bri);
            logic [8:0]   h;
            logic [11:0]  h6;
            logic [11:0]  rem;
            logic [15:0]  frac;
            logic [16:0]  s_q;
            logic [16:0]  v_q;
            logic [16:0]  sf;
            logic [16:0]  p;
            logic [16:0]  q;
            logic [16:0]  t;
            hsvc_sector_t sec;
            rgb_pixel_t   px;
            // gray passes brightness through unscaled
            if (sat == 8'd0)
            begin
                px.red   = bri;
                px.green = bri;
                px.blue  = bri;
                return px;
            end
            // hue wrap, sector and fraction within sector
            h    = (hue >= HUE_SPAN) ? 9'(hue - HUE_SPAN) : hue;
            h6   = 12'(SECTOR_COUNT * h);
            sec  = hsvc_sector_t'(h6 / HUE_SPAN);
            rem  = 12'(h6 % HUE_SPAN);
            frac = 16'((32'(rem) << 16) / HUE_SPAN);
            // ratios never reach one since both fields stay below their span
            s_q  = 17'((32'(sat) << 16) / SAT_FULL);
            v_q  = 17'((32'(bri) << 16) / VAL_FULL);
            sf   = 17'((longint'(s_q) * frac) >> 16);
            p    = shade(v_q, s_q);
            q    = shade(v_q, sf);
            t    = shade(v_q, 17'(s_q - sf));
            case (sec)
                SEC_RED:
                begin
                    px.red = to_channel(v_q); px.green = to_channel(t);
                    px.blue = to_channel(p);
                end
                SEC_YELLOW:
                begin
                    px.red = to_channel(q); px.green = to_channel(v_q);
                    px.blue = to_channel(p);
                end
                SEC_GREEN:
                begin
                    px.red = to_channel(p); px.green = to_channel(v_q);
                    px.blue = to_channel(t);
                end
                SEC_CYAN:
                begin
                    px.red = to_channel(p); px.green = to_channel(q);
                    px.blue = to_channel(v_q);
                end
                SEC_BLUE:
                begin
                    px.red = to_channel(t); px.green = to_channel(p);
                    px.blue = to_channel(v_q);
                end
                default:
                begin
                    px.red = to_channel(v_q); px.green = to_channel(p);
                    px.blue = to_channel(q);
                end
            endcase
            return px;
        endfunction

        function void note_request(logic [8:0] hue, logic [7:0] sat, logic [7:0] bri);
            expected_rgb.push_back(rgb_of_hsv(hue, sat, bri));
        endfunction

        task report_mismatch(string what, logic [7:0] want, logic [7:0] got);
            $display("%0t: mismatch on %s: expected %0d, got %0d", $realtime, what, want, got);
            mismatches++;
        endtask

        task check_result(logic [7:0] red, logic [7:0] green, logic [7:0] blue);
            rgb_pixel_t want;
            if (expected_rgb.size() == 0)
            begin
                $display("%0t: rgb result %0d %0d %0d with no request pending",
                         $realtime, red, green, blue);
                mismatches++;
                return;
            end
            want = expected_rgb.pop_front();
            if (red !== want.red)
                report_mismatch("red", want.red, red);
            if (green !== want.green)
                report_mismatch("green", want.green, green);
            if (blue !== want.blue)
                report_mismatch("blue", want.blue, blue);
        endtask
    endclass

    logic clk;
    logic rst_n;
    bit   steady;
    int   idle_cycles;

    pixel_scoreboard sb = new();

    hsvc_hsv_if hsv_ch ();
    hsvc_rgb_if rgb_ch ();

    hsv_to_rgb_converter dut (
        .clk   (clk),
        .rst_n (rst_n),
        .hsv   (hsv_ch),
        .rgb   (rgb_ch)
    );

    // 10 ns clock
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // rgb side stalls at random outside the steady stretch
    always @(posedge clk)
    begin
        rgb_ch.ready <= steady || ($urandom_range(99) >= 6);
    end

    // monitor both channels and watch for a hang
    always @(posedge clk)
    begin
        if (rst_n && hsv_ch.valid && hsv_ch.ready)
            sb.note_request(hsv_ch.hue, hsv_ch.saturation, hsv_ch.brightness);
        if (rst_n && rgb_ch.valid && rgb_ch.ready)
            sb.check_result(rgb_ch.red, rgb_ch.green, rgb_ch.blue);
        if ((hsv_ch.valid && hsv_ch.ready) || (rgb_ch.valid && rgb_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // one hsv request, with random gaps before it
    task send_pixel(input logic [8:0] hue, input logic [7:0] sat, input logic [7:0] bri);
        while (!steady && $urandom_range(99) < 6)
        begin
            hsv_ch.valid <= 1'b0;
            @(posedge clk);
        end
        hsv_ch.valid      <= 1'b1;
        hsv_ch.hue        <= hue;
        hsv_ch.saturation <= sat;
        hsv_ch.brightness <= bri;
        do
            @(posedge clk);
        while (!hsv_ch.ready);
    endtask

    initial
    begin
        logic [8:0] hue;
        logic [7:0] sat;
        logic [7:0] bri;
        hsv_ch.valid      = 1'b0;
        hsv_ch.hue        = '0;
        hsv_ch.saturation = '0;
        hsv_ch.brightness = '0;
        rgb_ch.ready      = 1'b0;
        rst_n             = 1'b0;
        steady            = 1'b0;
        idle_cycles       = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // gray pixels, including out of range hue
        send_pixel(9'd0,   8'd0,   8'd0);
        send_pixel(9'd0,   8'd0,   8'd255);
        send_pixel(9'd511, 8'd0,   8'd128);
        // sector starts at full saturation and value
        send_pixel(9'd0,   8'd255, 8'd255);
        send_pixel(9'd60,  8'd255, 8'd255);
        send_pixel(9'd120, 8'd255, 8'd255);
        send_pixel(9'd180, 8'd255, 8'd255);
        send_pixel(9'd240, 8'd255, 8'd255);
        send_pixel(9'd300, 8'd255, 8'd255);
        // sector middles
        send_pixel(9'd30,  8'd128, 8'd200);
        send_pixel(9'd90,  8'd128, 8'd200);
        send_pixel(9'd150, 8'd128, 8'd200);
        send_pixel(9'd210, 8'd128, 8'd200);
        send_pixel(9'd270, 8'd128, 8'd200);
        send_pixel(9'd330, 8'd128, 8'd200);
        // last hue, full range wrap and hue beyond the range
        send_pixel(9'd359, 8'd255, 8'd255);
        send_pixel(9'd360, 8'd255, 8'd255);
        send_pixel(9'd361, 8'd200, 8'd200);
        send_pixel(9'd511, 8'd255, 8'd255);
        // smallest saturation and brightness
        send_pixel(9'd59,  8'd1,   8'd255);
        send_pixel(9'd1,   8'd255, 8'd1);
        send_pixel(9'd360, 8'd1,   8'd0);

        // random pixels, mostly hue in range, some gray
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            steady = (i >= 600 && i < 900);
            if ($urandom_range(99) < 85)
                hue = 9'($urandom_range(0, HUE_SPAN));
            else
                hue = 9'($urandom_range(HUE_SPAN + 1, 511));
            if ($urandom_range(99) < 5)
                sat = 8'd0;
            else
                sat = 8'($urandom_range(0, 255));
            bri = 8'($urandom_range(0, 255));
            send_pixel(hue, sat, bri);
        end
        steady = 1'b0;
        hsv_ch.valid <= 1'b0;

        // drain the pipeline
        while (sb.expected_rgb.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.mismatches == 0 && sb.expected_rgb.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ----- hsv_to_rgb_converter.f -----
sv/hsvc_pkg.sv
sv/hsvc_if.sv
sv/hsvc_sector_stage.sv
sv/hsvc_term_stage.sv
sv/hsvc_round_stage.sv
sv/hsv_to_rgb_converter.sv
test/tb_hsv_to_rgb_converter.sv
